// ----- src/sha256_pkg.sv -----
// ============================================================================
// SHA-256 compression package
// Shared types, the initial hash value, the round constants and the
// SHA-256 helper functions.
// ============================================================================
package sha256_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [7:0][31:0]  t_hash;    // index 0 is word a / H0
    typedef logic [15:0][31:0] t_window;  // index 0 is the oldest word

    localparam int unsigned NUM_ROUNDS  = 64;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam t_word INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [0:NUM_ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic t_word choose(input t_word x, input t_word y, input t_word z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic t_word majority(input t_word x, input t_word y, input t_word z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

endpackage

// ----- src/sha256_ifs.sv -----
// ============================================================================
// SHA-256 stream interfaces
// Valid/ready channels for message words in and digest words out.
// ============================================================================
interface sha256_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic        message_start;
    logic        message_end;

    modport source (output valid, output msg_word, output message_start,
                    output message_end, input ready);
    modport sink   (input valid, input msg_word, input message_start,
                    input message_end, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// ----- src/sha256_round.sv -----
// ============================================================================
// SHA-256 round unit
// One compression round plus one step of the message schedule expansion.
// ============================================================================
module sha256_round
    import sha256_pkg::*;
(
    input  t_hash   i_work,
    input  t_window i_window,
    input  t_word   i_k,
    output t_hash   o_work,
    output t_word   o_new_word
);

    t_word t1;
    t_word t2;

    always_comb begin
        t1 = i_work[7] + big_sigma1(i_work[4]) + choose(i_work[4], i_work[5], i_work[6])
           + i_k + i_window[0];
        t2 = big_sigma0(i_work[0]) + majority(i_work[0], i_work[1], i_work[2]);

        o_work[0] = t1 + t2;
        o_work[1] = i_work[0];
        o_work[2] = i_work[1];
        o_work[3] = i_work[2];
        o_work[4] = i_work[3] + t1;
        o_work[5] = i_work[4];
        o_work[6] = i_work[5];
        o_work[7] = i_work[6];
    end

    // W[t+16] from the rolling window that holds W[t] .. W[t+15].
    assign o_new_word = small_sigma1(i_window[14]) + i_window[9]
                      + small_sigma0(i_window[1]) + i_window[0];

endmodule

// ----- src/sha256_block_compress_unit.sv -----
// ============================================================================
// SHA-256 block compression unit
// Absorbs padded message words and runs the SHA-256 compression function.
// ============================================================================
// Usage:
// The input channel i_msg carries one 32-bit big-endian word of an already
// padded message per transaction, sixteen per 512-bit block. Set
// message_start on the first word of a message to reload the initial hash
// value; set message_end on the sixteenth word of the final block to get
// the digest.
// Words that do not complete a block are taken one per cycle. The word
// that completes a block starts the compression: 64 rounds, one per cycle
// on a single shared round unit, then a final step that adds the working
// variables into the chaining words; ready stays low through both.
// When message_end was set, the eight digest words H0..H7 follow on the
// output channel o_dig, one transaction each, the last marked with
// digest_last. The first digest word is valid in the cycle after the final
// addition. Input ready stays low until the eighth word is taken; a stalled
// receiver simply holds the block with the current word on the port.
// Reset (synchronous, active low) restores the initial hash value, clears
// the word count and leaves both channels idle.
// ============================================================================
module sha256_block_compress_unit
    import sha256_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     i_msg,
    sha256_out_if.source  o_dig
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // Control state.
    logic [1:0] r_state, n_state;
    logic [3:0] r_count, n_count;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx,   n_idx;
    logic       r_end,   n_end;
    t_hash      r_chain, n_chain;

    // Datapath state; never read before it is written.
    t_window    r_window, n_window;
    t_hash      r_work,   n_work;

    t_hash      rnd_work;
    t_word      rnd_new_word;

    logic       in_fire;
    logic       out_fire;
    logic [3:0] eff_count;
    t_hash      init_hash;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            init_hash[i] = INIT_HASH[i];
        end
    end

    sha256_round u_round (
        .i_work     (r_work),
        .i_window   (r_window),
        .i_k        (ROUND_K[r_round]),
        .o_work     (rnd_work),
        .o_new_word (rnd_new_word)
    );

    assign i_msg.ready       = (r_state == ST_IDLE);
    assign o_dig.valid       = (r_state == ST_OUT);
    assign o_dig.digest_word = r_chain[r_idx];
    assign o_dig.digest_last = (r_idx == 3'd7);

    assign in_fire  = i_msg.valid && i_msg.ready;
    assign out_fire = o_dig.valid && o_dig.ready;

    // A start flag restarts the block, so the word becomes word 0.
    assign eff_count = i_msg.message_start ? 4'd0 : r_count;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_round  = r_round;
        n_idx    = r_idx;
        n_end    = r_end;
        n_chain  = r_chain;
        n_window = r_window;
        n_work   = r_work;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    // The window shifts toward index 0, so after sixteen words
                    // it holds W0..W15 in order; stale words of a discarded
                    // partial block have been pushed out by then.
                    n_window = {i_msg.msg_word, r_window[15:1]};
                    if (i_msg.message_start) begin
                        n_chain = init_hash;
                    end
                    if (eff_count == 4'd15) begin
                        n_count = 4'd0;
                        n_round = 6'd0;
                        n_work  = r_chain;
                        n_end   = i_msg.message_end;
                        n_state = ST_ROUND;
                    end else begin
                        n_count = eff_count + 4'd1;
                    end
                end
            end
            ST_ROUND: begin
                n_work   = rnd_work;
                n_window = {rnd_new_word, r_window[15:1]};
                n_round  = r_round + 6'd1;
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_work[i];
                end
                n_idx   = 3'd0;
                n_state = r_end ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= 4'd0;
            r_round <= 6'd0;
            r_idx   <= 3'd0;
            r_end   <= 1'b0;
            r_chain <= init_hash;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_end   <= n_end;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
        r_work   <= n_work;
    end

endmodule

// ----- src/sha256_chk.sv -----
// ============================================================================
// SHA-256 compression port checker
// Watches the ports of the compression unit for handshake and sequencing slips.
// ============================================================================
module sha256_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic        i_out_last
);

    // Message words are never taken while a digest is being delivered.
    a_no_input_during_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while digest words are pending");

    // Reset leaves the output channel idle.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("digest valid right after reset");

    // A digest ends with its last word; the block then returns to idle.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("digest did not end after its last word");

    // A stalled digest word holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_word) && $stable(i_out_last)))
        else $error("digest word changed while stalled");

endmodule

bind sha256_block_compress_unit sha256_chk u_sha256_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_msg.ready),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_word  (o_dig.digest_word),
    .i_out_last  (o_dig.digest_last)
);
